### hw/rtl/srw_pkg.sv
`default_nettype none
package srw_pkg;

  // Widest sequence number the command path carries
  localparam int unsigned SeqWMax = 8;

  // Event kinds as they arrive on the input channel
  localparam logic [2:0] KIND_NET = 3'd0;
  localparam logic [2:0] KIND_PHY = 3'd1;
  localparam logic [2:0] KIND_FRM = 3'd2;
  localparam logic [2:0] KIND_DTO = 3'd3;
  localparam logic [2:0] KIND_ATO = 3'd4;

  // Received frame types
  localparam logic [1:0] FRM_DATA = 2'd0;
  localparam logic [1:0] FRM_ACK  = 2'd1;
  localparam logic [1:0] FRM_NAK  = 2'd2;

  // Classified operation handed from front to back
  typedef enum logic [3:0] {
    OP_NET,
    OP_PHY,
    OP_BAD,
    OP_DATA,
    OP_NAK,
    OP_ACKONLY,
    OP_DTO,
    OP_ATO,
    OP_IGN
  } op_e;

  // Result commands
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_DATA    = 3'd1,
    ACT_ACK     = 3'd2,
    ACT_NAK     = 3'd3,
    ACT_STORE   = 3'd4,
    ACT_DELIVER = 3'd5,
    ACT_STOP    = 3'd6
  } act_e;

  typedef struct packed {
    op_e                op;
    logic [SeqWMax-1:0] seq;
    logic [SeqWMax-1:0] ackno;
  } cmd_t;

endpackage
`default_nettype wire

### hw/rtl/srw_evt_if.sv
`default_nettype none
interface srw_evt_if #(
  parameter int unsigned SEQ_BITS = 4
);
  logic                valid;
  logic                ready;
  logic [2:0]          kind;
  logic                frame_good;
  logic [1:0]          frame_type;
  logic [SEQ_BITS-1:0] frame_seq;
  logic [SEQ_BITS-1:0] frame_ackno;

  modport source (
    output valid, kind, frame_good, frame_type, frame_seq, frame_ackno,
    input  ready
  );
  modport sink (
    input  valid, kind, frame_good, frame_type, frame_seq, frame_ackno,
    output ready
  );
endinterface
`default_nettype wire

### hw/rtl/srw_res_if.sv
`default_nettype none
interface srw_res_if #(
  parameter int unsigned SEQ_BITS = 4
);
  logic                valid;
  logic                ready;
  logic [2:0]          action;
  logic [SEQ_BITS-1:0] out_seq;
  logic [SEQ_BITS-1:0] out_ackno;
  logic [2:0]          slot;
  logic                ack_timer_start;
  logic                ack_timer_stop;
  logic                network_enable;
  logic                last;

  modport source (
    output valid, action, out_seq, out_ackno, slot, ack_timer_start,
           ack_timer_stop, network_enable, last,
    input  ready
  );
  modport sink (
    input  valid, action, out_seq, out_ackno, slot, ack_timer_start,
           ack_timer_stop, network_enable, last,
    output ready
  );
endinterface
`default_nettype wire

### hw/rtl/srw_front.sv
`default_nettype none
module srw_front
  import srw_pkg::*;
#(
  parameter int unsigned SEQ_BITS = 4
) (
  srw_evt_if.sink evt_i,
  output cmd_t    cmd_o,
  output logic    cmd_valid_o,
  input  wire     cmd_ready_i
);

  op_e op;

  // Decode event kind, frame verdict and frame type into one operation
  always_comb begin
    unique case (evt_i.kind)
      KIND_NET: op = OP_NET;
      KIND_PHY: op = OP_PHY;
      KIND_FRM: begin
        if (!evt_i.frame_good) begin
          op = OP_BAD;
        end else if (evt_i.frame_type == FRM_DATA) begin
          op = OP_DATA;
        end else if (evt_i.frame_type == FRM_NAK) begin
          op = OP_NAK;
        end else begin
          op = OP_ACKONLY;
        end
      end
      KIND_DTO: op = OP_DTO;
      KIND_ATO: op = OP_ATO;
      default:  op = OP_IGN;
    endcase
  end

  assign cmd_o.op    = op;
  assign cmd_o.seq   = SeqWMax'(evt_i.frame_seq);
  assign cmd_o.ackno = SeqWMax'(evt_i.frame_ackno);
  assign cmd_valid_o = evt_i.valid;
  assign evt_i.ready = cmd_ready_i;

endmodule
`default_nettype wire

### hw/rtl/srw_queue.sv
`default_nettype none
module srw_queue
  import srw_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  cmd_t push_data_i,
  input  wire  push_valid_i,
  output logic push_ready_o,
  output cmd_t pop_data_o,
  output logic pop_valid_o,
  input  wire  pop_ready_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/srw_back.sv
`default_nettype none
module srw_back
  import srw_pkg::*;
#(
  parameter int unsigned SEQ_BITS = 4,
  parameter int unsigned WINDOW   = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cmd_t       cmd_i,
  input  wire        cmd_valid_i,
  output logic       cmd_ready_o,
  srw_res_if.source  res_o
);

  localparam int unsigned IW = $clog2(WINDOW);
  localparam int unsigned GW = $clog2(WINDOW + 1);
  localparam int unsigned S  = SEQ_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STORE = 3'd1;
  localparam logic [2:0] ST_DELIV = 3'd2;
  localparam logic [2:0] ST_STOP  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  typedef struct packed {
    act_e         action;
    logic [S-1:0] seq;
    logic [S-1:0] ackno;
    logic [2:0]   slot;
    logic         start;
    logic         stop;
  } res_t;

  typedef struct packed {
    res_t res;
    logic en;
    logic last;
  } out_t;

  function automatic logic in_win(input logic [S-1:0] a, input logic [S-1:0] b,
                                  input logic [S-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic res_t mk(input act_e a, input logic [S-1:0] sq,
                              input logic [S-1:0] ak, input logic [2:0] sl,
                              input logic st, input logic sp);
    res_t r;
    r.action = a;
    r.seq    = sq;
    r.ackno  = ak;
    r.slot   = sl;
    r.start  = st;
    r.stop   = sp;
    return r;
  endfunction

  // Sequence number to slot lookup
  logic [IW-1:0] slot_tab [2**SEQ_BITS];
  for (genvar g = 0; g < 2**SEQ_BITS; g++) begin : g_slot
    assign slot_tab[g] = IW'(g % WINDOW);
  end

  logic [2:0]        state_q, state_d;
  logic [S-1:0]      sle_q, sle_d, sns_q, sns_d, rle_q, rle_d, rhe_q, rhe_d;
  logic [S-1:0]      oc_q, oc_d;
  logic [WINDOW-1:0] marks_q, marks_d;
  logic              nak_ok_q, nak_ok_d, phy_q, phy_d;
  logic [GW-1:0]     guard_q, guard_d;
  logic [S-1:0]      seq_q, seq_d, ack_q, ack_d;
  logic              en_q, en_d;
  logic              pend_vld_q, pend_vld_d;
  res_t              pend_q, pend_d;
  logic              out_vld_q, out_vld_d;
  out_t              out_q, out_d;

  logic         go, emit, fin;
  res_t         r;
  logic [S-1:0] cseq, cack, ack1, ackv, n_stop, oc_fin;
  logic         aw, aw1, rw, oc_room, phy_fin;

  assign go   = !out_vld_q || res_o.ready;
  assign cseq = (state_q == ST_IDLE) ? S'(cmd_i.seq) : seq_q;
  assign cack = (state_q == ST_IDLE) ? S'(cmd_i.ackno) : ack_q;
  assign ack1 = cack + S'(1);
  assign ackv = rle_q - S'(1);
  assign aw   = in_win(sle_q, cack, sns_q);
  assign aw1  = in_win(sle_q, ack1, sns_q);
  assign rw   = in_win(rle_q, cseq, rhe_q);
  assign oc_room = 32'(oc_q) < WINDOW;
  assign n_stop  = aw ? (cack - sle_q + S'(1)) : '0;

  // Outstanding count and physical-ready as they stand after the whole event
  always_comb begin
    oc_fin  = oc_q;
    phy_fin = phy_q;
    unique case (cmd_i.op)
      OP_NET: begin
        if (oc_room) begin
          oc_fin  = oc_q + S'(1);
          phy_fin = 1'b0;
        end
      end
      OP_PHY: phy_fin = 1'b1;
      OP_BAD: phy_fin = nak_ok_q ? 1'b0 : phy_q;
      OP_DATA: begin
        oc_fin  = oc_q - n_stop;
        phy_fin = ((cseq != rle_q) && nak_ok_q) ? 1'b0 : phy_q;
      end
      OP_NAK: begin
        oc_fin  = oc_q - n_stop;
        phy_fin = aw1 ? 1'b0 : phy_q;
      end
      OP_ACKONLY: oc_fin = oc_q - n_stop;
      OP_DTO, OP_ATO: phy_fin = 1'b0;
      default: ;
    endcase
  end

  // Event sequencer
  always_comb begin
    state_d  = state_q;
    sle_d    = sle_q;
    sns_d    = sns_q;
    rle_d    = rle_q;
    rhe_d    = rhe_q;
    oc_d     = oc_q;
    marks_d  = marks_q;
    nak_ok_d = nak_ok_q;
    phy_d    = phy_q;
    guard_d  = guard_q;
    seq_d    = seq_q;
    ack_d    = ack_q;
    en_d     = en_q;
    emit     = 1'b0;
    fin      = 1'b0;
    r        = mk(ACT_NONE, '0, '0, '0, 1'b0, 1'b0);
    cmd_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && go) begin
          cmd_ready_o = 1'b1;
          seq_d   = cseq;
          ack_d   = cack;
          en_d    = (32'(oc_fin) < WINDOW) && phy_fin;
          state_d = ST_FIN;
          unique case (cmd_i.op)
            OP_NET: begin
              if (oc_room) begin
                emit  = 1'b1;
                r     = mk(ACT_DATA, sns_q, ackv, 3'(slot_tab[sns_q]), 1'b0, 1'b1);
                oc_d  = oc_q + S'(1);
                sns_d = sns_q + S'(1);
                phy_d = 1'b0;
              end
            end
            OP_PHY: phy_d = 1'b1;
            OP_BAD: begin
              if (nak_ok_q) begin
                emit     = 1'b1;
                r        = mk(ACT_NAK, '0, ackv, '0, 1'b0, 1'b1);
                nak_ok_d = 1'b0;
                phy_d    = 1'b0;
              end
            end
            OP_DATA: begin
              emit = 1'b1;
              if ((cseq != rle_q) && nak_ok_q) begin
                r        = mk(ACT_NAK, '0, ackv, '0, 1'b0, 1'b1);
                nak_ok_d = 1'b0;
                phy_d    = 1'b0;
              end else begin
                r = mk(ACT_NONE, '0, '0, '0, 1'b1, 1'b0);
              end
              state_d = ST_STORE;
            end
            OP_NAK: begin
              if (aw1) begin
                emit  = 1'b1;
                r     = mk(ACT_DATA, ack1, ackv, 3'(slot_tab[ack1]), 1'b0, 1'b1);
                phy_d = 1'b0;
              end
              state_d = ST_STOP;
            end
            OP_ACKONLY: state_d = ST_STOP;
            OP_DTO: begin
              emit  = 1'b1;
              r     = mk(ACT_DATA, sle_q, ackv, 3'(slot_tab[sle_q]), 1'b0, 1'b1);
              phy_d = 1'b0;
            end
            OP_ATO: begin
              emit  = 1'b1;
              r     = mk(ACT_ACK, '0, ackv, '0, 1'b0, 1'b1);
              phy_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_STORE: begin
        if (go) begin
          if (rw && !marks_q[slot_tab[seq_q]]) begin
            emit    = 1'b1;
            r       = mk(ACT_STORE, seq_q, '0, 3'(slot_tab[seq_q]), 1'b0, 1'b0);
            marks_d[slot_tab[seq_q]] = 1'b1;
            guard_d = '0;
            state_d = ST_DELIV;
          end else begin
            state_d = ST_STOP;
          end
        end
      end
      ST_DELIV: begin
        if (go) begin
          if (marks_q[slot_tab[rle_q]] && (guard_q < GW'(WINDOW))) begin
            emit     = 1'b1;
            r        = mk(ACT_DELIVER, rle_q, '0, 3'(slot_tab[rle_q]), 1'b1, 1'b0);
            nak_ok_d = 1'b1;
            marks_d[slot_tab[rle_q]] = 1'b0;
            rle_d    = rle_q + S'(1);
            rhe_d    = rhe_q + S'(1);
            guard_d  = guard_q + GW'(1);
          end else begin
            state_d = ST_STOP;
          end
        end
      end
      ST_STOP: begin
        if (go) begin
          if (aw) begin
            emit  = 1'b1;
            r     = mk(ACT_STOP, sle_q, '0, 3'(slot_tab[sle_q]), 1'b0, 1'b0);
            oc_d  = oc_q - S'(1);
            sle_d = sle_q + S'(1);
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (go) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // One result is held back so the final one can be marked
  always_comb begin
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && !res_o.ready;
    out_d      = out_q;
    if (emit) begin
      if (pend_vld_q) begin
        out_vld_d    = 1'b1;
        out_d.res    = pend_q;
        out_d.en     = en_d;
        out_d.last   = 1'b0;
      end
      pend_d     = r;
      pend_vld_d = 1'b1;
    end else if (fin) begin
      out_vld_d  = 1'b1;
      out_d.res  = pend_vld_q ? pend_q : mk(ACT_NONE, '0, '0, '0, 1'b0, 1'b0);
      out_d.en   = en_q;
      out_d.last = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sle_q      <= '0;
      sns_q      <= '0;
      rle_q      <= '0;
      rhe_q      <= S'(WINDOW);
      oc_q       <= '0;
      marks_q    <= '0;
      nak_ok_q   <= 1'b1;
      phy_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      sle_q      <= sle_d;
      sns_q      <= sns_d;
      rle_q      <= rle_d;
      rhe_q      <= rhe_d;
      oc_q       <= oc_d;
      marks_q    <= marks_d;
      nak_ok_q   <= nak_ok_d;
      phy_q      <= phy_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    guard_q <= guard_d;
    seq_q   <= seq_d;
    ack_q   <= ack_d;
    en_q    <= en_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.action          = out_q.res.action;
  assign res_o.out_seq         = out_q.res.seq;
  assign res_o.out_ackno       = out_q.res.ackno;
  assign res_o.slot            = out_q.res.slot;
  assign res_o.ack_timer_start = out_q.res.start;
  assign res_o.ack_timer_stop  = out_q.res.stop;
  assign res_o.network_enable  = out_q.en;
  assign res_o.last            = out_q.last;

endmodule
`default_nettype wire

### hw/rtl/selective_repeat_window_control.sv
// Channel | Dir | Transfer
// evt_i   | in  | one event: kind, frame verdict, type, seq, ack number
// res_o   | out | one command; last marks the final command of an event
//
// An event steps the sequencer through the event, a store check and delivery
// walk for data, an ack scan for good frames, and a finish step. The back
// sequencer handles one event at a time; a two-entry queue lets the front
// take new events meanwhile. Reset zeroes the marks and the window edges but
// sets rhe to WINDOW. A stalled output register holds the sequencer in place.
`default_nettype none
module selective_repeat_window_control
  import srw_pkg::*;
#(
  parameter int unsigned SEQ_BITS = 4,
  parameter int unsigned WINDOW   = 8
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  srw_evt_if.sink   evt_i,
  srw_res_if.source res_o
);

  cmd_t front_cmd, back_cmd;
  logic front_vld, front_rdy, back_vld, back_rdy;

  srw_front #(
    .SEQ_BITS (SEQ_BITS)
  ) u_front (
    .evt_i       (evt_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_vld),
    .cmd_ready_i (front_rdy)
  );

  srw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_vld),
    .push_ready_o (front_rdy),
    .pop_data_o   (back_cmd),
    .pop_valid_o  (back_vld),
    .pop_ready_i  (back_rdy)
  );

  srw_back #(
    .SEQ_BITS (SEQ_BITS),
    .WINDOW   (WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_vld),
    .cmd_ready_o (back_rdy),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire

### dv/tb.sv
module tb;
  import srw_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  srw_evt_if #(.SEQ_BITS(4)) evt ();
  srw_res_if #(.SEQ_BITS(4)) res ();

  selective_repeat_window_control #(.SEQ_BITS(4), .WINDOW(8)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt),
    .res_o (res)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [2:0] kind;
    logic       good;
    logic [1:0] ftype;
    logic [3:0] seq;
    logic [3:0] ackno;
  } event_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] seq;
    logic [3:0] ackno;
    logic [2:0] slot;
    logic       t_start;
    logic       t_stop;
    logic       net_en;
    logic       last;
  } command_t;

  // Link window state mirrored on the bench side
  logic [3:0] snd_lo, snd_nxt, rcv_lo, rcv_hi, in_flight;
  logic [7:0] arrived;
  logic       nak_ok, phy_rdy;

  command_t cmd_q[$];
  command_t ev_cmds[$];
  int       errors = 0;

  function automatic bit between(logic [3:0] a, logic [3:0] b, logic [3:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic void push_cmd(act_e a, logic [3:0] s, logic [3:0] k,
                                   logic [2:0] sl, logic st, logic sp);
    command_t c;
    c = '0;
    c.action = a; c.seq = s; c.ackno = k; c.slot = sl;
    c.t_start = st; c.t_stop = sp;
    if (ev_cmds.size() < 20) ev_cmds.push_back(c);
  endfunction

  function automatic void send_data(logic [3:0] s);
    push_cmd(ACT_DATA, s, rcv_lo - 4'd1, s[2:0], 1'b0, 1'b1);
    phy_rdy = 1'b0;
  endfunction

  function automatic void send_ctrl(bit is_nak);
    push_cmd(is_nak ? ACT_NAK : ACT_ACK, 4'd0, rcv_lo - 4'd1, 3'd0, 1'b0, 1'b1);
    if (is_nak) nak_ok = 1'b0;
    phy_rdy = 1'b0;
  endfunction

  function automatic void clear_link();
    snd_lo = 0; snd_nxt = 0; rcv_lo = 0; rcv_hi = 4'd8;
    in_flight = 0; arrived = '0; nak_ok = 1'b1; phy_rdy = 1'b0;
  endfunction

  // Work out the commands one event causes and queue them
  function automatic void predict_event(event_t e);
    int guard;
    logic en;
    ev_cmds.delete();
    case (e.kind)
      KIND_NET: if (in_flight < 8) begin
        in_flight = in_flight + 1;
        send_data(snd_nxt);
        snd_nxt = snd_nxt + 1;
      end
      KIND_PHY: phy_rdy = 1'b1;
      KIND_FRM: begin
        if (!e.good) begin
          if (nak_ok) send_ctrl(1);
        end else begin
          if (e.ftype == FRM_DATA) begin
            if (e.seq != rcv_lo && nak_ok) send_ctrl(1);
            else push_cmd(ACT_NONE, 0, 0, 0, 1'b1, 1'b0);
            if (between(rcv_lo, e.seq, rcv_hi) && !arrived[e.seq[2:0]]) begin
              arrived[e.seq[2:0]] = 1'b1;
              push_cmd(ACT_STORE, e.seq, 0, e.seq[2:0], 1'b0, 1'b0);
              guard = 0;
              while (arrived[rcv_lo[2:0]] && guard < 8) begin
                push_cmd(ACT_DELIVER, rcv_lo, 0, rcv_lo[2:0], 1'b1, 1'b0);
                nak_ok = 1'b1;
                arrived[rcv_lo[2:0]] = 1'b0;
                rcv_lo = rcv_lo + 1;
                rcv_hi = rcv_hi + 1;
                guard++;
              end
            end
          end else if (e.ftype == FRM_NAK && between(snd_lo, e.ackno + 4'd1, snd_nxt)) begin
            send_data(e.ackno + 4'd1);
          end
          guard = 0;
          while (between(snd_lo, e.ackno, snd_nxt) && guard <= 15) begin
            in_flight = in_flight - 1;
            push_cmd(ACT_STOP, snd_lo, 0, snd_lo[2:0], 1'b0, 1'b0);
            snd_lo = snd_lo + 1;
            guard++;
          end
        end
      end
      KIND_DTO: send_data(snd_lo);
      KIND_ATO: send_ctrl(0);
      default: ;
    endcase
    if (ev_cmds.size() == 0) push_cmd(ACT_NONE, 0, 0, 0, 1'b0, 1'b0);
    en = (in_flight < 8) && phy_rdy;
    foreach (ev_cmds[i]) begin
      ev_cmds[i].net_en = en;
      ev_cmds[i].last = (i == ev_cmds.size() - 1);
      cmd_q.push_back(ev_cmds[i]);
    end
  endfunction

  // Directed events; a typed row's expected first command is checked against the first predicted command
  typedef struct {
    event_t   e;
    bit       typed;
    command_t first;
  } row_t;

  row_t rows[$];

  function automatic void add_row(logic [2:0] k, logic g, logic [1:0] t,
                                  logic [3:0] s, logic [3:0] a,
                                  bit typed = 0, command_t f = '0);
    row_t r;
    r.e = '{k, g, t, s, a};
    r.typed = typed;
    r.first = f;
    rows.push_back(r);
  endfunction

  // Event source
  int sent = 0;

  task automatic drive(event_t e);
    evt.valid <= 1'b1;
    evt.kind <= e.kind; evt.frame_good <= e.good; evt.frame_type <= e.ftype;
    evt.frame_seq <= e.seq; evt.frame_ackno <= e.ackno;
    predict_event(e);
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic pause_maybe(ref int burst);
    if (burst == 0) begin
      evt.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst = $urandom_range(1, 12);
    end else burst--;
  endtask

  function automatic event_t rand_event();
    event_t e;
    int p;
    p = $urandom_range(0, 99);
    e.good = ($urandom_range(0, 9) != 0);
    e.ftype = $urandom_range(0, 3);
    e.seq = $urandom;
    e.ackno = $urandom;
    if (p < 22) e.kind = KIND_NET;
    else if (p < 40) e.kind = KIND_PHY;
    else if (p < 85) begin
      e.kind = KIND_FRM;
      // mostly plausible frames near the windows
      if ($urandom_range(0, 3) != 0) begin
        e.seq = rcv_lo + $urandom_range(0, 9);
        e.ackno = snd_lo + $urandom_range(0, 8) - 1;
        if ($urandom_range(0, 2) != 0) e.ftype = $urandom_range(0, 2);
      end
    end else if (p < 92) e.kind = KIND_DTO;
    else if (p < 98) e.kind = KIND_ATO;
    else e.kind = $urandom_range(5, 7);
    return e;
  endfunction

  initial begin
    int burst;
    event_t e;
    command_t f;
    evt.valid = 1'b0; evt.kind = '0; evt.frame_good = 1'b0;
    evt.frame_type = '0; evt.frame_seq = '0; evt.frame_ackno = '0;
    clear_link();

    // After reset: data timeout resends seq 0 with ack number 15
    f = '0; f.action = ACT_DATA; f.ackno = 4'd15; f.t_stop = 1'b1; f.last = 1'b1;
    add_row(KIND_DTO, 0, 0, 0, 0, 1, f);
    f = '0; f.action = ACT_ACK; f.ackno = 4'd15; f.t_stop = 1'b1; f.last = 1'b1;
    add_row(KIND_ATO, 0, 0, 0, 0, 1, f);
    f = '0; f.action = ACT_NAK; f.ackno = 4'd15; f.t_stop = 1'b1; f.last = 1'b1;
    add_row(KIND_FRM, 0, FRM_DATA, 0, 0, 1, f);       // bad frame, nak allowed
    f = '0; f.action = ACT_NONE; f.last = 1'b1;
    add_row(KIND_FRM, 0, FRM_DATA, 4'd15, 4'd15, 1, f); // bad frame, nak spent
    add_row(3'd7, 1, 2'd3, 4'd15, 4'd15, 1, f);       // unknown kind
    add_row(3'd5, 0, 0, 0, 0, 1, f);
    add_row(KIND_PHY, 1, 0, 0, 0);
    for (int i = 0; i < 9; i++) add_row(KIND_NET, 0, 0, 0, 0); // fills window
    add_row(KIND_FRM, 1, FRM_NAK, 4'd2, 4'd15);       // nak resends seq 0
    add_row(KIND_FRM, 1, FRM_NAK, 4'd0, 4'd10);       // nak outside window
    add_row(KIND_FRM, 1, FRM_ACK, 4'd0, 4'd3);        // ack frees four
    add_row(KIND_FRM, 1, 2'd3, 4'd0, 4'd7);           // unknown type, ack only
    add_row(KIND_FRM, 1, FRM_DATA, 4'd1, 4'd7);       // out of order, nak spent
    add_row(KIND_FRM, 1, FRM_DATA, 4'd0, 4'd7);       // fills gap, delivers two
    add_row(KIND_FRM, 1, FRM_DATA, 4'd12, 4'd7);      // outside receive window
    add_row(KIND_FRM, 1, FRM_DATA, 4'd2, 4'd7);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      drive(rows[i].e);
      if (rows[i].typed && ev_cmds[0] !== rows[i].first) begin
        $display("%0t: directed row %0d exp %p act-pred %p", $time, i,
                 rows[i].first, ev_cmds[0]);
        errors++;
      end
    end

    burst = $urandom_range(1, 12);
    for (int n = 0; n < 270; n++) begin
      e = rand_event();
      drive(e);
      if (n > 40 && n < 80) burst = 1; // a stretch without gaps
      else pause_maybe(burst);
    end
    evt.valid <= 1'b0;

    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Result sink: stalls on its own pattern
  int stall_cnt = 0;
  initial res.ready = 1'b0;
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if ((stall_cnt / 64) % 3 == 2) res.ready <= 1'b1;
    else res.ready <= ($urandom_range(0, 3) != 0);
  end

  // Compare each accepted command with the oldest expectation
  always @(posedge clk_i) begin
    command_t got, want;
    if (rst_ni && res.valid && res.ready) begin
      got = '{res.action, res.out_seq, res.out_ackno, res.slot,
              res.ack_timer_start, res.ack_timer_stop, res.network_enable, res.last};
      if (cmd_q.size() == 0) begin
        $display("%0t: unexpected command exp none act %p", $time, got);
        errors++;
      end else begin
        want = cmd_q.pop_front();
        if (got !== want) begin
          $display("%0t: command mismatch exp %p act %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/srw_pkg.sv
hw/rtl/srw_evt_if.sv
hw/rtl/srw_res_if.sv
hw/rtl/srw_front.sv
hw/rtl/srw_queue.sv
hw/rtl/srw_back.sv
hw/rtl/selective_repeat_window_control.sv
dv/tb.sv
